[design/elcsr_pkg.sv]
package elcsr_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;
    localparam int NODE_W    = 10;
    localparam int CNT_W     = 11;
    localparam int EDGE_W    = 14;
    localparam int ADDR_W    = $clog2(MAX_EDGES);
    localparam int WGT_W     = 64;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 11;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OFFSET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADJ    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd3;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_SYMMETRIC  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_CHECK, OP_WR2, OP_CLR, OP_CTR0, OP_CRD, OP_CINC_RD,
        OP_CINC_WR, OP_PRD, OP_PWR, OP_PEND, OP_SRD, OP_SFRD, OP_SWR, OP_RRD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic res;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             last;
        logic             chk_wr2;
        logic             chk_err;
        logic             st_err;
        logic             done_e;
        logic             done_n;
        logic             out_free;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_WR2, S_CLR, S_CRD, S_CINC, S_CWR, S_PRD, S_PWR,
        S_SRD, S_SFRD, S_SWR, S_RDW, S_RES
    } t_state;

endpackage

[design/elcsr_ctrl.sv]
module elcsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  elcsr_pkg::t_stat i_stat,
    output elcsr_pkg::t_cmd  o_cmd,
    output logic             o_stall
);
    import elcsr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        o_cmd.res = 1'b0;
        o_stall   = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.req == REQ_LOAD) begin
                    o_cmd.op = OP_CHECK;
                    if (i_stat.chk_wr2) n_state = S_WR2;
                    else if (i_stat.last) n_state = S_CLR;
                    else if (i_stat.chk_err) n_state = S_RES;
                    else n_state = S_IDLE;
                end else if (i_stat.req == REQ_OFFSET || i_stat.req == REQ_ADJ) begin
                    o_cmd.op = OP_RRD;
                    n_state  = S_RDW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WR2: begin
                o_cmd.op = OP_WR2;
                if (i_stat.last) n_state = S_CLR;
                else if (i_stat.st_err) n_state = S_RES;
                else n_state = S_IDLE;
            end
            S_CLR: begin
                if (i_stat.done_n) begin
                    o_cmd.op = OP_CTR0;
                    n_state  = S_CRD;
                end else begin
                    o_cmd.op = OP_CLR;
                end
            end
            S_CRD: begin
                if (i_stat.done_e) begin
                    o_cmd.op = OP_CTR0;
                    n_state  = S_PRD;
                end else begin
                    o_cmd.op = OP_CRD;
                    n_state  = S_CINC;
                end
            end
            S_CINC: begin
                o_cmd.op = OP_CINC_RD;
                n_state  = S_CWR;
            end
            S_CWR: begin
                o_cmd.op = OP_CINC_WR;
                n_state  = S_CRD;
            end
            S_PRD: begin
                if (i_stat.done_n) begin
                    o_cmd.op = OP_PEND;
                    n_state  = S_SRD;
                end else begin
                    o_cmd.op = OP_PRD;
                    n_state  = S_PWR;
                end
            end
            S_PWR: begin
                o_cmd.op = OP_PWR;
                n_state  = S_PRD;
            end
            S_SRD: begin
                if (i_stat.done_e) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.op = OP_SRD;
                    n_state  = S_SFRD;
                end
            end
            S_SFRD: begin
                o_cmd.op = OP_SFRD;
                n_state  = S_SWR;
            end
            S_SWR: begin
                o_cmd.op = OP_SWR;
                n_state  = S_SRD;
            end
            S_RDW: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.res = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res |-> i_stat.out_free) else $error("result loaded while output busy");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_ACCEPT |=> o_stall) else $error("stall low after accept");
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res |=> !o_stall) else $error("not idle after result");

endmodule

[design/elcsr_dp.sv]
module elcsr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  elcsr_pkg::t_cmd                  i_cmd,
    output elcsr_pkg::t_stat                 o_stat,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [elcsr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [elcsr_pkg::REQ_W-1:0]      i_req_type,
    input  logic [elcsr_pkg::NODE_W-1:0]     i_source_node,
    input  logic [elcsr_pkg::NODE_W-1:0]     i_dest_node,
    input  logic [elcsr_pkg::WGT_W-1:0]      i_edge_weight,
    input  logic                             i_last_edge,
    input  logic [elcsr_pkg::EDGE_W-1:0]     i_read_index,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [elcsr_pkg::STAT_W-1:0]     o_status,
    output logic [elcsr_pkg::CNT_W-1:0]      o_total_nodes,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_total_edges,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_min_degree,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_max_degree,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_offset_value,
    output logic [elcsr_pkg::NODE_W-1:0]     o_adjacent_node,
    output logic [elcsr_pkg::WGT_W-1:0]      o_adjacent_weight
);
    import elcsr_pkg::*;

    logic [CNT_W-1:0]  r_node_count;
    logic              r_sym;
    logic [REQ_W-1:0]  r_req;
    logic [NODE_W-1:0] r_src, r_dst;
    logic [WGT_W-1:0]  r_w;
    logic              r_last;
    logic [EDGE_W-1:0] r_idx;
    logic [EDGE_W-1:0] r_stored, r_ctr, r_sum, r_min, r_max, r_edges;
    logic [CNT_W-1:0]  r_nodes;
    logic              r_built;
    logic [STAT_W-1:0] r_st;

    logic [2*NODE_W+WGT_W-1:0] mem_coo [MAX_EDGES];
    logic [NODE_W+WGT_W-1:0]   mem_adj [MAX_EDGES];
    logic [EDGE_W-1:0]         mem_cnt [MAX_NODES];
    logic [EDGE_W-1:0]         mem_off [MAX_NODES+1];

    logic [NODE_W-1:0] r_cq_src, r_cq_dst;
    logic [WGT_W-1:0]  r_cq_w;
    logic [EDGE_W-1:0] r_cnt_q, r_off_q;
    logic [NODE_W-1:0] r_aq_node;
    logic [WGT_W-1:0]  r_aq_w;

    logic [CNT_W-1:0]    eff_n;
    logic [EDGE_W-1:0]   stored_eff;
    logic                need2, chk_bad, chk_over, e_ok;
    logic [STAT_W-1:0]   chk_st, rd_st;
    logic [EDGE_W:0]     need_sum;

    logic                      coo_we, coo_re, cnt_we, cnt_re, off_we, adj_we;
    logic [ADDR_W-1:0]         coo_wa;
    logic [2*NODE_W+WGT_W-1:0] coo_wd;
    logic [NODE_W-1:0]         cnt_wa, cnt_ra;
    logic [EDGE_W-1:0]         cnt_wd;
    logic [CNT_W-1:0]          off_wa;
    logic [EDGE_W-1:0]         off_wd;

    logic r_ovalid;

    always_comb begin
        eff_n = r_node_count;
        if (r_node_count == '0) eff_n = CNT_W'(1);
        if (r_node_count > CNT_W'(MAX_NODES)) eff_n = CNT_W'(MAX_NODES);
        stored_eff = r_built ? '0 : r_stored;
        need2    = r_sym && (r_src != r_dst);
        chk_bad  = ({1'b0, r_src} >= eff_n) || ({1'b0, r_dst} >= eff_n);
        need_sum = {1'b0, stored_eff} + (need2 ? (EDGE_W+1)'(2) : (EDGE_W+1)'(1));
        chk_over = need_sum > (EDGE_W+1)'(MAX_EDGES);
        chk_st   = chk_bad ? ST_RANGE : (chk_over ? ST_OVERFLOW : ST_OK);
        e_ok     = ({1'b0, r_cq_src} < eff_n) && ({1'b0, r_cq_dst} < eff_n);
        if (!r_built) rd_st = ST_NOT_BUILT;
        else if (r_req == REQ_OFFSET) rd_st = (r_idx <= EDGE_W'(r_nodes)) ? ST_OK : ST_RANGE;
        else rd_st = (r_idx < r_edges) ? ST_OK : ST_RANGE;
    end

    assign o_stat.req      = r_req;
    assign o_stat.last     = r_last;
    assign o_stat.chk_wr2  = (chk_st == ST_OK) && need2;
    assign o_stat.chk_err  = (chk_st != ST_OK);
    assign o_stat.st_err   = (r_st != ST_OK);
    assign o_stat.done_e   = (r_ctr == r_stored);
    assign o_stat.done_n   = (r_ctr == EDGE_W'(eff_n));
    assign o_stat.out_free = !r_ovalid || !i_stall;

    always_comb begin
        coo_we = 1'b0;
        coo_wa = stored_eff[ADDR_W-1:0];
        coo_wd = {r_src, r_dst, r_w};
        coo_re = (i_cmd.op == OP_CRD) || (i_cmd.op == OP_SRD);
        cnt_we = 1'b0;
        cnt_wa = r_ctr[NODE_W-1:0];
        cnt_wd = '0;
        cnt_re = 1'b0;
        cnt_ra = r_ctr[NODE_W-1:0];
        off_we = 1'b0;
        off_wa = r_ctr[CNT_W-1:0];
        off_wd = r_sum;
        adj_we = 1'b0;
        case (i_cmd.op)
            OP_CHECK: coo_we = (chk_st == ST_OK);
            OP_WR2: begin
                coo_we = 1'b1;
                coo_wa = r_stored[ADDR_W-1:0];
                coo_wd = {r_dst, r_src, r_w};
            end
            OP_CLR: cnt_we = 1'b1;
            OP_CINC_RD, OP_SFRD: begin
                cnt_re = 1'b1;
                cnt_ra = r_cq_src;
            end
            OP_CINC_WR: begin
                cnt_we = e_ok;
                cnt_wa = r_cq_src;
                cnt_wd = r_cnt_q + EDGE_W'(1);
            end
            OP_PRD: cnt_re = 1'b1;
            OP_PWR: begin
                cnt_we = 1'b1;
                cnt_wd = r_sum;
                off_we = 1'b1;
            end
            OP_PEND: begin
                off_we = 1'b1;
                off_wa = eff_n;
            end
            OP_SWR: begin
                adj_we = e_ok;
                cnt_we = e_ok;
                cnt_wa = r_cq_src;
                cnt_wd = r_cnt_q + EDGE_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (coo_we) mem_coo[coo_wa] <= coo_wd;
        if (coo_re) {r_cq_src, r_cq_dst, r_cq_w} <= mem_coo[r_ctr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) mem_cnt[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_q <= mem_cnt[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (off_we) mem_off[off_wa] <= off_wd;
        if (i_cmd.op == OP_RRD) r_off_q <= mem_off[r_idx[CNT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) mem_adj[r_cnt_q[ADDR_W-1:0]] <= {r_cq_dst, r_cq_w};
        if (i_cmd.op == OP_RRD) {r_aq_node, r_aq_w} <= mem_adj[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(MAX_NODES);
            r_sym        <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_NODE_COUNT) r_node_count <= i_cfg_data;
            else r_sym <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT) begin
            r_req  <= i_req_type;
            r_src  <= i_source_node;
            r_dst  <= i_dest_node;
            r_w    <= i_edge_weight;
            r_last <= i_last_edge;
            r_idx  <= i_read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_built  <= 1'b0;
            r_ctr    <= '0;
            r_sum    <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_nodes  <= '0;
            r_edges  <= '0;
            r_st     <= ST_OK;
        end else begin
            case (i_cmd.op)
                OP_CHECK: begin
                    r_built  <= 1'b0;
                    r_st     <= chk_st;
                    r_stored <= stored_eff + EDGE_W'(chk_st == ST_OK);
                    r_ctr    <= '0;
                    r_sum    <= '0;
                    r_min    <= '1;
                    r_max    <= '0;
                end
                OP_WR2:  r_stored <= r_stored + EDGE_W'(1);
                OP_CLR, OP_CINC_WR, OP_SWR: r_ctr <= r_ctr + EDGE_W'(1);
                OP_CTR0: r_ctr <= '0;
                OP_PWR: begin
                    r_ctr <= r_ctr + EDGE_W'(1);
                    r_sum <= r_sum + r_cnt_q;
                    if (r_cnt_q < r_min) r_min <= r_cnt_q;
                    if (r_cnt_q > r_max) r_max <= r_cnt_q;
                end
                OP_PEND: begin
                    r_ctr   <= '0;
                    r_nodes <= eff_n;
                    r_edges <= r_sum;
                    r_built <= 1'b1;
                end
                OP_RRD: r_st <= rd_st;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.res) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res) begin
            o_status          <= r_st;
            o_total_nodes     <= r_built ? r_nodes : '0;
            o_total_edges     <= r_built ? r_edges : '0;
            o_min_degree      <= r_built ? r_min : '0;
            o_max_degree      <= r_built ? r_max : '0;
            o_offset_value    <= (r_req == REQ_OFFSET && r_st == ST_OK) ? r_off_q : '0;
            o_adjacent_node   <= (r_req == REQ_ADJ && r_st == ST_OK) ? r_aq_node : '0;
            o_adjacent_weight <= (r_req == REQ_ADJ && r_st == ST_OK) ? r_aq_w : '0;
        end
    end

    assign o_valid = r_ovalid;

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= EDGE_W'(MAX_EDGES)) else $error("edge store count past capacity");
    a_built_after_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_PEND |=> r_built) else $error("build not flagged");
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SWR && e_ok) |-> r_cnt_q < r_edges)
        else $error("scatter slot out of range");

endmodule

[design/edge_list_to_csr_builder.sv]
// Edge list to CSR builder. Edges are loaded one item at a time; in
// symmetric mode a second write stores the reversed copy of an edge whose
// ends differ. The item marked last_edge triggers the build, which is run
// by a sequencer over single-port memories: it clears the degree counters,
// counts degrees over the stored edges, forms the prefix sum per node and
// then scatters the stored edges into the adjacency array. The build result
// follows with status and degree statistics; a load item that fails its
// range or capacity check also returns a result with its status. Offset
// and adjacency reads each return a result. Input stall is high whenever
// an item is in progress; a finished result waits in the output register
// without blocking the next item, but a later result waits behind it.
module edge_list_to_csr_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [elcsr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [elcsr_pkg::REQ_W-1:0]      i_req_type,
    input  logic [elcsr_pkg::NODE_W-1:0]     i_source_node,
    input  logic [elcsr_pkg::NODE_W-1:0]     i_dest_node,
    input  logic [elcsr_pkg::WGT_W-1:0]      i_edge_weight,
    input  logic                             i_last_edge,
    input  logic [elcsr_pkg::EDGE_W-1:0]     i_read_index,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [elcsr_pkg::STAT_W-1:0]     o_status,
    output logic [elcsr_pkg::CNT_W-1:0]      o_total_nodes,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_total_edges,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_min_degree,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_max_degree,
    output logic [elcsr_pkg::EDGE_W-1:0]     o_offset_value,
    output logic [elcsr_pkg::NODE_W-1:0]     o_adjacent_node,
    output logic [elcsr_pkg::WGT_W-1:0]      o_adjacent_weight
);
    import elcsr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    elcsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    elcsr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_source_node     (i_source_node),
        .i_dest_node       (i_dest_node),
        .i_edge_weight     (i_edge_weight),
        .i_last_edge       (i_last_edge),
        .i_read_index      (i_read_index),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_total_nodes     (o_total_nodes),
        .o_total_edges     (o_total_edges),
        .o_min_degree      (o_min_degree),
        .o_max_degree      (o_max_degree),
        .o_offset_value    (o_offset_value),
        .o_adjacent_node   (o_adjacent_node),
        .o_adjacent_weight (o_adjacent_weight)
    );

endmodule

[bench/edge_list_to_csr_builder_tb.sv]
module edge_list_to_csr_builder_tb;
    import elcsr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_INVALID = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  total_nodes;
        logic [EDGE_W-1:0] total_edges;
        logic [EDGE_W-1:0] min_degree;
        logic [EDGE_W-1:0] max_degree;
        logic [EDGE_W-1:0] offset_value;
        logic [NODE_W-1:0] adjacent_node;
        logic [WGT_W-1:0]  adjacent_weight;
    } csr_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [REQ_W-1:0]    i_req_type;
    logic [NODE_W-1:0]   i_source_node;
    logic [NODE_W-1:0]   i_dest_node;
    logic [WGT_W-1:0]    i_edge_weight;
    logic                i_last_edge;
    logic [EDGE_W-1:0]   i_read_index;
    logic                o_valid;
    logic                i_stall;
    logic [STAT_W-1:0]   o_status;
    logic [CNT_W-1:0]    o_total_nodes;
    logic [EDGE_W-1:0]   o_total_edges;
    logic [EDGE_W-1:0]   o_min_degree;
    logic [EDGE_W-1:0]   o_max_degree;
    logic [EDGE_W-1:0]   o_offset_value;
    logic [NODE_W-1:0]   o_adjacent_node;
    logic [WGT_W-1:0]    o_adjacent_weight;

    edge_list_to_csr_builder dut (.*);

    // graph model state
    logic [CFG_W-1:0]  node_cfg;
    logic              sym_cfg;
    logic [NODE_W-1:0] edge_src [MAX_EDGES];
    logic [NODE_W-1:0] edge_dst [MAX_EDGES];
    logic [WGT_W-1:0]  edge_wgt [MAX_EDGES];
    logic [NODE_W-1:0] adj_node [MAX_EDGES];
    logic [WGT_W-1:0]  adj_wgt  [MAX_EDGES];
    int                row_off  [MAX_NODES+1];
    int                fill_pos [MAX_NODES];
    int                edge_cnt;
    bit                is_built;
    int                b_nodes, b_edges, b_min, b_max;

    csr_result_t exp_results[$];
    int          fails;
    int          burst_left;
    int          gap_max;
    int          stall_pct;
    int          hold_cycles;
    int          items_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #36000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int eff_nodes();
        if (node_cfg == 0) return 1;
        if (node_cfg > MAX_NODES) return MAX_NODES;
        return int'(node_cfg);
    endfunction

    function automatic void store_edge(int s, int d, logic [WGT_W-1:0] w);
        edge_src[edge_cnt] = NODE_W'(s);
        edge_dst[edge_cnt] = NODE_W'(d);
        edge_wgt[edge_cnt] = w;
        edge_cnt++;
    endfunction

    function automatic void build_csr();
        int n;
        int sum;
        int c;
        int p;
        int dg;
        n = eff_nodes();
        sum = 0;
        for (int i = 0; i <= MAX_NODES; i++) row_off[i] = 0;
        for (int e = 0; e < edge_cnt; e++)
            if (edge_src[e] < n && edge_dst[e] < n) row_off[edge_src[e]]++;
        for (int i = 0; i < n; i++) begin
            c = row_off[i];
            row_off[i] = sum;
            fill_pos[i] = sum;
            sum += c;
        end
        row_off[n] = sum;
        for (int e = 0; e < edge_cnt; e++) begin
            if (edge_src[e] < n && edge_dst[e] < n) begin
                p = fill_pos[edge_src[e]];
                fill_pos[edge_src[e]] = p + 1;
                adj_node[p] = edge_dst[e];
                adj_wgt[p] = edge_wgt[e];
            end
        end
        b_min = 32'h7fffffff;
        b_max = 0;
        for (int i = 0; i < n; i++) begin
            dg = row_off[i+1] - row_off[i];
            if (dg < b_min) b_min = dg;
            if (dg > b_max) b_max = dg;
        end
        b_nodes = n;
        b_edges = sum;
        is_built = 1;
    endfunction

    function automatic void fill_stats(ref csr_result_t r);
        r.total_nodes = CNT_W'(b_nodes);
        r.total_edges = EDGE_W'(b_edges);
        r.min_degree = EDGE_W'(b_min);
        r.max_degree = EDGE_W'(b_max);
    endfunction

    function automatic void predict_csr(input logic [REQ_W-1:0] req, input int s, input int d,
                                        input logic [WGT_W-1:0] w, input bit last,
                                        input int idx);
        csr_result_t r;
        int n;
        int need;
        r = '0;
        if (req == REQ_LOAD) begin
            if (is_built) begin
                is_built = 0;
                edge_cnt = 0;
                b_nodes = 0; b_edges = 0; b_min = 0; b_max = 0;
            end
            n = eff_nodes();
            r.status = ST_OK;
            if (s >= n || d >= n) begin
                r.status = ST_RANGE;
            end else begin
                need = (sym_cfg && s != d) ? 2 : 1;
                if (edge_cnt + need > MAX_EDGES) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    store_edge(s, d, w);
                    if (need == 2) store_edge(d, s, w);
                end
            end
            if (last) begin
                build_csr();
                fill_stats(r);
                exp_results.push_back(r);
            end else if (r.status != ST_OK) begin
                exp_results.push_back(r);
            end
        end else if (req == REQ_OFFSET || req == REQ_ADJ) begin
            if (!is_built) begin
                r.status = ST_NOT_BUILT;
            end else begin
                fill_stats(r);
                if (req == REQ_OFFSET) begin
                    if (idx <= b_nodes) r.offset_value = EDGE_W'(row_off[idx]);
                    else r.status = ST_RANGE;
                end else begin
                    if (idx < b_edges) begin
                        r.adjacent_node = adj_node[idx];
                        r.adjacent_weight = adj_wgt[idx];
                    end else begin
                        r.status = ST_RANGE;
                    end
                end
            end
            exp_results.push_back(r);
        end
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input int s, input int d,
                             input logic [WGT_W-1:0] w, input bit last, input int idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req_type <= req;
        i_source_node <= NODE_W'(s);
        i_dest_node <= NODE_W'(d);
        i_edge_weight <= w;
        i_last_edge <= last;
        i_read_index <= EDGE_W'(idx);
        do @(posedge i_clk); while (o_stall);
        predict_csr(req, s, d, w, last, idx);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input int val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NODE_COUNT) node_cfg = CFG_W'(val);
        else sym_cfg = val[0];
    endtask

    function automatic logic [WGT_W-1:0] rand_wgt();
        return {$urandom, $urandom};
    endfunction

    task automatic load_edge(input int s, input int d, input bit last);
        send_item(REQ_LOAD, s, d, rand_wgt(), last, 0);
    endtask

    task automatic read_req(input logic [REQ_W-1:0] req, input int idx);
        send_item(req, $urandom_range(0, 1023), $urandom_range(0, 1023), rand_wgt(),
                  1'($urandom_range(0, 1)), idx);
    endtask

    task automatic test_reads_before_build();
        read_req(REQ_OFFSET, 0);
        read_req(REQ_ADJ, 16383);
        read_req(REQ_INVALID, 5);
    endtask

    task automatic test_basic_build();
        write_cfg(CFG_NODE_COUNT, 4);
        write_cfg(CFG_SYMMETRIC, 0);
        load_edge(0, 1, 0);
        load_edge(0, 3, 0);
        load_edge(2, 2, 0);
        load_edge(4, 0, 0);
        load_edge(3, 0, 0);
        load_edge(1, 1023, 1);
        for (int i = 0; i <= 5; i++) read_req(REQ_OFFSET, i);
        for (int i = 0; i <= 4; i++) read_req(REQ_ADJ, i);
    endtask

    task automatic test_symmetric();
        write_cfg(CFG_SYMMETRIC, 1);
        write_cfg(CFG_NODE_COUNT, 3);
        load_edge(0, 2, 0);
        load_edge(1, 1, 0);
        load_edge(2, 1, 1);
        read_req(REQ_ADJ, 0);
        read_req(REQ_ADJ, 4);
        read_req(REQ_OFFSET, 3);
    endtask

    task automatic test_node_count_change();
        write_cfg(CFG_SYMMETRIC, 0);
        write_cfg(CFG_NODE_COUNT, 1024);
        load_edge(1023, 0, 0);
        load_edge(1, 2, 0);
        load_edge(5, 9, 0);
        write_cfg(CFG_NODE_COUNT, 6);
        load_edge(0, 1, 1);
        read_req(REQ_OFFSET, 6);
        read_req(REQ_ADJ, 1);
    endtask

    task automatic test_node_extremes();
        write_cfg(CFG_NODE_COUNT, 0);
        load_edge(0, 0, 0);
        load_edge(0, 1, 1);
        read_req(REQ_OFFSET, 1);
        read_req(REQ_OFFSET, 2);
        write_cfg(CFG_NODE_COUNT, 2047);
        load_edge(1023, 1023, 1);
        read_req(REQ_OFFSET, 1024);
        read_req(REQ_OFFSET, 1025);
    endtask

    task automatic test_store_full();
        int s;
        write_cfg(CFG_NODE_COUNT, 1024);
        write_cfg(CFG_SYMMETRIC, 1);
        gap_max = 1;
        for (int i = 0; i < MAX_EDGES / 2; i++) begin
            s = $urandom_range(0, 1023);
            load_edge(s, (s + 1 + $urandom_range(0, 1021)) % 1024, 0);
        end
        load_edge(10, 20, 0);
        load_edge(7, 7, 0);
        load_edge(3, 4, 1);
        read_req(REQ_ADJ, MAX_EDGES - 1);
        read_req(REQ_ADJ, MAX_EDGES);
        read_req(REQ_OFFSET, 512);
        gap_max = 6;
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_NODE_COUNT, 8);
        write_cfg(CFG_SYMMETRIC, 0);
        for (int i = 0; i < 6; i++) load_edge($urandom_range(0, 7), $urandom_range(0, 7), 0);
        load_edge(0, 0, 1);
        hold_cycles = 300;
        for (int i = 0; i < 12; i++) read_req(REQ_OFFSET, $urandom_range(0, 9));
        drain();
    endtask

    task automatic test_random();
        int n;
        int k;
        int m;
        int idx;
        int pick;
        logic [REQ_W-1:0] req;
        while (items_sent < 4700) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) n = 1024;
            else if (pick == 1) n = 0;
            else if (pick == 2) n = 1025 + $urandom_range(0, 1022);
            else n = $urandom_range(1, 16);
            write_cfg(CFG_NODE_COUNT, n);
            write_cfg(CFG_SYMMETRIC, $urandom_range(0, 1));
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
            n = eff_nodes();
            k = $urandom_range(1, 20);
            for (int i = 0; i < k; i++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0 && n < 1024)
                    load_edge($urandom_range(n, 1023), $urandom_range(0, 1023), i == k - 1);
                else if (pick == 1)
                    read_req($urandom_range(0, 1) ? REQ_OFFSET : REQ_ADJ,
                             $urandom_range(0, 16383));
                else if (pick == 2)
                    read_req(REQ_INVALID, $urandom_range(0, 16383));
                else
                    load_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), i == k - 1);
            end
            m = $urandom_range(2, 14);
            for (int i = 0; i < m; i++) begin
                req = $urandom_range(0, 1) ? REQ_OFFSET : REQ_ADJ;
                pick = $urandom_range(0, 9);
                if (pick == 0) idx = $urandom_range(0, 16383);
                else if (req == REQ_OFFSET) idx = $urandom_range(0, b_nodes + 1);
                else idx = $urandom_range(0, b_edges);
                read_req(req, idx);
            end
        end
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        csr_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_results.size() == 0) begin
                $error("unexpected result, status %0d", o_status);
                fails++;
            end else begin
                e = exp_results.pop_front();
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("total_nodes", 64'(e.total_nodes), 64'(o_total_nodes));
                check_field("total_edges", 64'(e.total_edges), 64'(o_total_edges));
                check_field("min_degree", 64'(e.min_degree), 64'(o_min_degree));
                check_field("max_degree", 64'(e.max_degree), 64'(o_max_degree));
                check_field("offset_value", 64'(e.offset_value), 64'(o_offset_value));
                check_field("adjacent_node", 64'(e.adjacent_node), 64'(o_adjacent_node));
                check_field("adjacent_weight", e.adjacent_weight, o_adjacent_weight);
            end
        end
    end

    initial begin
        fails = 0;
        burst_left = 0;
        gap_max = 6;
        stall_pct = 30;
        hold_cycles = 0;
        items_sent = 0;
        node_cfg = 1024;
        sym_cfg = 0;
        edge_cnt = 0;
        is_built = 0;
        b_nodes = 0; b_edges = 0; b_min = 0; b_max = 0;
        for (int i = 0; i <= MAX_NODES; i++) row_off[i] = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_req_type <= '0;
        i_source_node <= '0;
        i_dest_node <= '0;
        i_edge_weight <= '0;
        i_last_edge <= 1'b0;
        i_read_index <= '0;
        i_stall <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reads_before_build();
        test_basic_build();
        test_symmetric();
        test_node_count_change();
        test_node_extremes();
        test_backpressure();
        test_store_full();
        test_random();
        drain();
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
